// ----- design/cms_pkg.sv -----
// Shared types and constants of the clustering mode sequencer.
`default_nettype none

package cms_pkg;

	typedef enum logic [1:0] {
		MODE_TYPICAL = 2'd0,
		MODE_BUBBLE  = 2'd1,
		MODE_MERGE   = 2'd2,
		MODE_NURTURE = 2'd3
	} mode_t;

	typedef enum logic {
		FUNC_BEGIN = 1'b0,
		FUNC_END   = 1'b1
	} func_t;

	typedef enum logic {
		REG_DISCARD = 1'b0,
		REG_TARGET  = 1'b1
	} reg_idx_t;

	localparam int DISCARD_BITS = 8;
	localparam int TARGET_BITS  = 11;
	localparam int CFG_BITS     = 11;
	localparam int COUNT_BITS   = 16;
	localparam int TIME_BITS    = 32;

	typedef logic signed [COUNT_BITS-1:0] count_t;

	localparam logic [DISCARD_BITS-1:0] DISCARD_RESET = 8'd3;
	localparam logic [TARGET_BITS-1:0]  TARGET_RESET  = 11'd5;
	localparam count_t                  COUNT_MAX     = 16'sd32767;
	localparam logic [TIME_BITS-1:0]    EARLY_STEPS   = 32'd20;
	localparam logic [1:0]              PEAK_LIMIT    = 2'd2;

	localparam int MERGE_SM_MIN  = 1;
	localparam int MERGE_SB_MIN  = 3;
	localparam int BUBBLE_SM_MIN = 2;
	localparam int BUBBLE_SB_MIN = 14;
	localparam int NURT_SM_MIN   = 1;
	localparam int NURT_SB_MAX   = 5;
	localparam int PEAK_LABEL_MIN = 2;

	typedef struct packed {
		mode_t mode;
		logic  terminate;
		logic  save_partition;
	} cms_result_t;

endpackage

`default_nettype wire

// ----- design/clustering_mode_sequencer_unit.sv -----
// Top level of the clustering mode sequencer: stream ports, input and output registers.
//
//  channel | direction | contents
//  s_      | in        | tuser: func; tdata: step_time, labels_seen, merge_stable
//  m_      | out       | tdata: mode, terminate, save_partition
//  cfg_    | in        | write enable, register index, data
//
// One transaction per cycle when m_tready stays high; the path from input
// acceptance to m_tvalid runs through the input register, then the result register.
// The state update between the two registers sets the rate.
// Reset returns the valid flags and all core state to their start values; no clearing pass is needed.
// When m_tready is low the result register holds and one more input is held.
`default_nettype none

module clustering_mode_sequencer_unit import cms_pkg::*; #(
	parameter int LABEL_BITS = 24,
	parameter int SINCE_BITS = 8
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cfg_we,
	input  wire logic                                     cfg_index,
	input  wire logic [CFG_BITS-1:0]                      cfg_data,
	input  wire logic                                     s_tvalid,
	output logic                                          s_tready,
	// step_time, labels_seen, merge_stable, zero fill
	input  wire logic [((TIME_BITS+LABEL_BITS+1+7)/8)*8-1:0] s_tdata,
	// func
	input  wire logic                                     s_tuser,
	output logic                                          m_tvalid,
	input  wire logic                                     m_tready,
	// mode, terminate, save_partition, zero fill
	output logic [7:0]                                    m_tdata
);

	localparam int LB_LO = TIME_BITS;
	localparam int MS_AT = TIME_BITS + LABEL_BITS;

	logic                  valid_s1;
	logic                  func_s1;
	logic [TIME_BITS-1:0]  time_s1;
	logic [LABEL_BITS-1:0] labels_s1;
	logic                  stable_s1;
	logic                  out_valid_q;
	cms_result_t           result_q;
	cms_result_t           core_result;
	logic                  advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1   <= s_tuser;
			time_s1   <= s_tdata[TIME_BITS-1:0];
			labels_s1 <= s_tdata[LB_LO +: LABEL_BITS];
			stable_s1 <= s_tdata[MS_AT];
		end
	end

	cms_core #(
		.LABEL_BITS (LABEL_BITS),
		.SINCE_BITS (SINCE_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (advance),
		.func         (func_s1),
		.step_time    (time_s1),
		.labels_seen  (labels_s1),
		.merge_stable (stable_s1),
		.result       (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= core_result;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, result_q.save_partition, result_q.terminate, result_q.mode};

endmodule

`default_nettype wire

// ----- design/cms_core.sv -----
// Mode selection and end-of-step state update of the clustering mode sequencer.
`default_nettype none

module cms_core import cms_pkg::*; #(
	parameter int LABEL_BITS = 24,
	parameter int SINCE_BITS = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic                    cfg_index,
	input  wire logic [CFG_BITS-1:0]     cfg_data,
	input  wire logic                    item_valid,
	input  wire logic                    func,
	input  wire logic [TIME_BITS-1:0]    step_time,
	input  wire logic [LABEL_BITS-1:0]   labels_seen,
	input  wire logic                    merge_stable,
	output cms_result_t                  result
);

	localparam int PW = LABEL_BITS + 4;
	localparam logic [SINCE_BITS-1:0] SINCE_MAX = {SINCE_BITS{1'b1}};

	logic [DISCARD_BITS-1:0] discard_q;
	logic [TARGET_BITS-1:0]  target_q;
	mode_t                   mode_q, mode_n;
	logic [SINCE_BITS-1:0]   since_q [4];
	logic [SINCE_BITS-1:0]   since_n [4];
	logic                    merge_allowed_q, merge_allowed_n;
	logic                    stable_q, stable_n;
	logic                    peaked_q, peaked_n;
	logic [1:0]              sap_q, sap_n;
	logic [LABEL_BITS-1:0]   peak_q, peak_n;
	logic [LABEL_BITS-1:0]   last_q, last_n;
	count_t                  count_q, count_n;
	logic                    event_q, event_n;

	logic [SINCE_BITS-1:0]   sm, sb;
	logic [PW-1:0]           p_ext, l_ext, ten_p, nine_l;
	logic                    peak_hit, peaked_eff;
	logic [1:0]              sap_inc;
	logic [SINCE_BITS-1:0]   sv;

	assign sm = since_q[MODE_MERGE];
	assign sb = since_q[MODE_BUBBLE];
	assign p_ext  = PW'(peak_q);
	assign l_ext  = PW'(labels_seen);
	assign ten_p  = (p_ext << 3) + (p_ext << 1);
	assign nine_l = (l_ext << 3) + l_ext;
	assign peak_hit = !peaked_q && (l_ext > PW'(PEAK_LABEL_MIN)) && (ten_p > nine_l);
	assign peaked_eff = peaked_q | peak_hit;
	assign sap_inc = sap_q + 2'd1;

	always_comb begin
		mode_n          = mode_q;
		since_n         = since_q;
		merge_allowed_n = merge_allowed_q;
		stable_n        = stable_q;
		peaked_n        = peaked_q;
		sap_n           = sap_q;
		peak_n          = peak_q;
		last_n          = last_q;
		count_n         = count_q;
		event_n         = event_q;
		sv              = '0;
		if (func == FUNC_BEGIN) begin
			mode_n = MODE_TYPICAL;
			if (step_time >= EARLY_STEPS) begin
				if (merge_allowed_q) begin
					if (sm > SINCE_BITS'(MERGE_SM_MIN) && sb > SINCE_BITS'(MERGE_SB_MIN))
						mode_n = MODE_MERGE;
				end else if (sm > SINCE_BITS'(BUBBLE_SM_MIN)
					&& sb > SINCE_BITS'(BUBBLE_SB_MIN)) begin
					mode_n = MODE_BUBBLE;
				end else if (sm > SINCE_BITS'(NURT_SM_MIN) && sb < SINCE_BITS'(NURT_SB_MAX)) begin
					mode_n = MODE_NURTURE;
				end
			end
		end else begin
			event_n = 1'b0;
			for (int i = 0; i < 4; i++) begin
				sv = (mode_q == mode_t'(i)) ? '0 : since_q[i];
				since_n[i] = (sv < SINCE_MAX) ? sv + 1'b1 : sv;
			end
			case (mode_q)
				MODE_BUBBLE: begin
					last_n = labels_seen;
					if (!peaked_q) begin
						peaked_n = peak_hit;
						if (labels_seen > peak_q)
							peak_n = labels_seen;
					end
					if (peaked_eff) begin
						sap_n = sap_inc;
						if (sap_inc >= PEAK_LIMIT) begin
							sap_n = 2'd0;
							merge_allowed_n = 1'b1;
						end
					end
				end
				MODE_MERGE: begin
					stable_n = merge_stable;
					peaked_n = 1'b0;
					sap_n    = 2'd0;
					peak_n   = '0;
					if (merge_stable) begin
						merge_allowed_n = 1'b0;
						if (count_q < COUNT_MAX)
							count_n = count_q + 16'sd1;
						event_n = (count_n > 16'sd0);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign result.mode           = mode_n;
	assign result.terminate      = (count_n >= $signed({5'b0, target_q}));
	assign result.save_partition = event_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discard_q       <= DISCARD_RESET;
			target_q        <= TARGET_RESET;
			mode_q          <= MODE_TYPICAL;
			since_q         <= '{default: '0};
			merge_allowed_q <= 1'b0;
			stable_q        <= 1'b0;
			peaked_q        <= 1'b0;
			sap_q           <= 2'd0;
			peak_q          <= '0;
			last_q          <= '0;
			count_q         <= 16'sd1 - $signed({8'b0, DISCARD_RESET});
			event_q         <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DISCARD: begin
					discard_q <= cfg_data[DISCARD_BITS-1:0];
					count_q   <= 16'sd1 - $signed({8'b0, cfg_data[DISCARD_BITS-1:0]});
				end
				REG_TARGET: target_q <= cfg_data[TARGET_BITS-1:0];
				default: begin
				end
			endcase
		end else if (item_valid) begin
			mode_q          <= mode_n;
			since_q         <= since_n;
			merge_allowed_q <= merge_allowed_n;
			stable_q        <= stable_n;
			peaked_q        <= peaked_n;
			sap_q           <= sap_n;
			peak_q          <= peak_n;
			last_q          <= last_n;
			count_q         <= count_n;
			event_q         <= event_n;
		end
	end

	a_early_typical: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !cfg_we && func == FUNC_BEGIN && step_time < EARLY_STEPS
		|=> mode_q == MODE_TYPICAL)
		else $error("early begin step left a non-typical mode");

	a_stable_merge_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !cfg_we && func == FUNC_END && mode_q == MODE_MERGE && merge_stable
		|=> !merge_allowed_q && !peaked_q)
		else $error("stable merge did not clear merge permission");

	a_bubble_since_reset: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !cfg_we && func == FUNC_END && mode_q == MODE_BUBBLE
		|=> since_q[MODE_BUBBLE] == SINCE_BITS'(1))
		else $error("bubble counter not restarted after bubble step");

	a_save_needs_count: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !cfg_we && func == FUNC_END && !(mode_q == MODE_MERGE && merge_stable)
		|=> !event_q)
		else $error("save flag raised without a stable merge");

endmodule

`default_nettype wire
